[sv/bpcr_pkg.sv]
// ----------------------------------------------------------------------------
// bpcr_pkg
// Types, widths and fixed-point constants shared by the disc pair collision
// response pipeline.
// ----------------------------------------------------------------------------
package bpcr_pkg;

	localparam int FRAC_BITS = 24;
	localparam int POS_W     = 32;
	localparam int RAD_W     = 24;
	localparam int RSUM_W    = RAD_W + 1;
	localparam int DIFF_W    = RSUM_W + 1;
	localparam int SQ_W      = 2 * RSUM_W;
	localparam int ROOT_W    = RSUM_W;
	localparam int NUM_W     = DIFF_W + FRAC_BITS;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int N_W       = FRAC_BITS + 2;
	localparam int OVL_W     = RSUM_W + 2;
	localparam int KC_W      = FRAC_BITS + 2;
	localparam int CLOSE_W   = POS_W + 4;
	localparam int TH_W      = CLOSE_W + 1;
	localparam int PP_W      = POS_W + 2;
	localparam int V1_W      = CLOSE_W + 1;
	localparam int H1_W      = TH_W + 1;
	localparam int P_NV_W    = N_W + POS_W + 1;
	localparam int P_NC_W    = N_W + CLOSE_W;
	localparam int P_OV_W    = N_W + OVL_W;
	localparam int P_D_W     = POS_W + KC_W;
	localparam int P_TH_W    = CLOSE_W + KC_W;
	localparam int P_K_W     = V1_W + KC_W;
	localparam int P_F_W     = H1_W + KC_W;
	localparam int WIDE_W    = 128;

	localparam longint EPS_RAW = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
	localparam logic [ROOT_W-1:0] EPS = (EPS_RAW == 0) ? ROOT_W'(1) : ROOT_W'(EPS_RAW);

	localparam logic signed [KC_W-1:0] K_DAMP = KC_W'(((64'd9 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [KC_W-1:0] K_GAIN = KC_W'(((64'd13 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [KC_W-1:0] K_KEEP =
		KC_W'(((64'd199 << FRAC_BITS) + 64'd100) / 64'd200);
	localparam logic signed [KC_W-1:0] K_FRIC = KC_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [KC_W-1:0] K_GND  =
		KC_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

	typedef struct packed {
		logic signed [POS_W-1:0] a_pos_h;
		logic signed [POS_W-1:0] a_pos_v;
		logic signed [POS_W-1:0] a_vel_h;
		logic signed [POS_W-1:0] a_vel_v;
		logic        [RAD_W-1:0] a_radius;
		logic signed [POS_W-1:0] b_pos_h;
		logic signed [POS_W-1:0] b_pos_v;
		logic signed [POS_W-1:0] b_vel_h;
		logic signed [POS_W-1:0] b_vel_v;
		logic        [RAD_W-1:0] b_radius;
	} in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] new_a_pos_h;
		logic signed [POS_W-1:0] new_a_pos_v;
		logic signed [POS_W-1:0] new_a_vel_h;
		logic signed [POS_W-1:0] new_a_vel_v;
		logic signed [POS_W-1:0] new_b_pos_h;
		logic signed [POS_W-1:0] new_b_pos_v;
		logic signed [POS_W-1:0] new_b_vel_h;
		logic signed [POS_W-1:0] new_b_vel_v;
		logic                    touching;
	} out_t;

	// side data that travels with a word through the root and divide stages
	typedef struct packed {
		in_t                      orig;
		logic                     touch;
		logic signed [DIFF_W-1:0] dh;
		logic signed [DIFF_W-1:0] dv;
		logic        [RSUM_W-1:0] rsum;
		logic signed [POS_W:0]    rvel_h;
		logic signed [POS_W:0]    rvel_v;
	} ctx_t;

	// shift right, rounding half away from zero
	function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] p,
		input int sh);
		logic [WIDE_W-1:0] m;
		logic [WIDE_W-1:0] r;
		m = p[WIDE_W-1] ? WIDE_W'(-p) : WIDE_W'(p);
		r = (m >> sh) + ((m >> (sh - 1)) & WIDE_W'(1));
		return p[WIDE_W-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(64'sd2147483647);
		lo = WIDE_W'(-64'sd2147483648);
		if (x > hi) begin
			return POS_W'(hi);
		end else if (x < lo) begin
			return POS_W'(lo);
		end
		return POS_W'(x);
	endfunction

endpackage

[sv/bpcr_sqrt.sv]
// ----------------------------------------------------------------------------
// bpcr_sqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bpcr_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_v,
	input  logic [bpcr_pkg::SQ_W-1:0] rad,
	input  bpcr_pkg::ctx_t            in_ctx,
	output logic                      out_v,
	output logic [bpcr_pkg::ROOT_W-1:0] root,
	output bpcr_pkg::ctx_t            out_ctx
);
	import bpcr_pkg::*;

	logic              v_s    [1:ROOT_W];
	logic [SQ_W-1:0]   rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	ctx_t              ctx_s  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;
		logic              v_in;
		logic [SQ_W-1:0]   rem_in;
		logic [ROOT_W-1:0] root_in;
		ctx_t              ctx_in;
		logic [SQ_W:0]     trial;

		if (k == 0) begin : g_first
			assign v_in    = in_v;
			assign rem_in  = rad;
			assign root_in = '0;
			assign ctx_in  = in_ctx;
		end else begin : g_next
			assign v_in    = v_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
			assign ctx_in  = ctx_s[k];
		end

		// (root + 2^B)^2 - root^2, with the low root bits still clear
		always_comb begin
			trial = ((SQ_W + 1)'(root_in) << (B + 1)) | ((SQ_W + 1)'(1) << (2 * B));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			ctx_s[k+1] <= ctx_in;
			if ({1'b0, rem_in} >= trial) begin
				rem_s[k+1]  <= rem_in - trial[SQ_W-1:0];
				root_s[k+1] <= root_in | (ROOT_W'(1) << B);
			end else begin
				rem_s[k+1]  <= rem_in;
				root_s[k+1] <= root_in;
			end
		end
	end

	assign out_v   = v_s[ROOT_W];
	assign root    = root_s[ROOT_W];
	assign out_ctx = ctx_s[ROOT_W];

endmodule

[sv/bpcr_div.sv]
// ----------------------------------------------------------------------------
// bpcr_div
// Distance floor, overlap, and two restoring dividers in lock step giving
// the rounded unit normal, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bpcr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_v,
	input  logic [bpcr_pkg::ROOT_W-1:0]  span,
	input  bpcr_pkg::ctx_t               in_ctx,
	output logic                         out_v,
	output logic signed [bpcr_pkg::N_W-1:0]   nh,
	output logic signed [bpcr_pkg::N_W-1:0]   nv,
	output logic signed [bpcr_pkg::OVL_W-1:0] overlap,
	output bpcr_pkg::ctx_t               out_ctx
);
	import bpcr_pkg::*;

	logic                    v_s    [0:QUO_W];
	logic [NUM_W-1:0]        remh_s [0:QUO_W];
	logic [NUM_W-1:0]        remv_s [0:QUO_W];
	logic [QUO_W-1:0]        qh_s   [0:QUO_W];
	logic [QUO_W-1:0]        qv_s   [0:QUO_W];
	logic [ROOT_W-1:0]       den_s  [0:QUO_W];
	logic signed [OVL_W-1:0] ovl_s  [0:QUO_W];
	ctx_t                    ctx_s  [0:QUO_W];

	logic [ROOT_W-1:0] dist_f;
	logic [DIFF_W-1:0] mag_h;
	logic [DIFF_W-1:0] mag_v;

	always_comb begin
		dist_f = (span < EPS) ? span + EPS : span;
		mag_h  = in_ctx.dh[DIFF_W-1] ? DIFF_W'(-in_ctx.dh) : DIFF_W'(in_ctx.dh);
		mag_v  = in_ctx.dv[DIFF_W-1] ? DIFF_W'(-in_ctx.dv) : DIFF_W'(in_ctx.dv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_v;
		end
	end

	// half the divisor added up front gives the round-half-up quotient
	always_ff @(posedge clk) begin
		remh_s[0] <= (NUM_W'(mag_h) << FRAC_BITS) + NUM_W'(dist_f >> 1);
		remv_s[0] <= (NUM_W'(mag_v) << FRAC_BITS) + NUM_W'(dist_f >> 1);
		qh_s[0]   <= '0;
		qv_s[0]   <= '0;
		den_s[0]  <= dist_f;
		ovl_s[0]  <= $signed(OVL_W'(in_ctx.rsum)) - $signed(OVL_W'(dist_f));
		ctx_s[0]  <= in_ctx;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int B = QUO_W - 1 - k;
		logic [NUM_W-1:0] sub;

		always_comb begin
			sub = NUM_W'(den_s[k]) << B;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
			ovl_s[k+1] <= ovl_s[k];
			ctx_s[k+1] <= ctx_s[k];
			if (remh_s[k] >= sub) begin
				remh_s[k+1] <= remh_s[k] - sub;
				qh_s[k+1]   <= qh_s[k] | (QUO_W'(1) << B);
			end else begin
				remh_s[k+1] <= remh_s[k];
				qh_s[k+1]   <= qh_s[k];
			end
			if (remv_s[k] >= sub) begin
				remv_s[k+1] <= remv_s[k] - sub;
				qv_s[k+1]   <= qv_s[k] | (QUO_W'(1) << B);
			end else begin
				remv_s[k+1] <= remv_s[k];
				qv_s[k+1]   <= qv_s[k];
			end
		end
	end

	always_comb begin
		out_v   = v_s[QUO_W];
		out_ctx = ctx_s[QUO_W];
		overlap = ovl_s[QUO_W];
		nh = ctx_s[QUO_W].dh[DIFF_W-1] ? -$signed(N_W'(qh_s[QUO_W])) : $signed(N_W'(qh_s[QUO_W]));
		nv = ctx_s[QUO_W].dv[DIFF_W-1] ? -$signed(N_W'(qv_s[QUO_W])) : $signed(N_W'(qv_s[QUO_W]));
	end

endmodule

[sv/bpcr_resp.sv]
// ----------------------------------------------------------------------------
// bpcr_resp
// Response pipeline: closing speed, push, velocity exchange, damping,
// ground friction, halving and saturation into the output register.
// ----------------------------------------------------------------------------
module bpcr_resp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_v,
	input  logic signed [bpcr_pkg::N_W-1:0]   nh,
	input  logic signed [bpcr_pkg::N_W-1:0]   nv,
	input  logic signed [bpcr_pkg::OVL_W-1:0] overlap,
	input  bpcr_pkg::ctx_t                    in_ctx,
	output logic                              done,
	output bpcr_pkg::out_t                    result
);
	import bpcr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7;

	logic signed [N_W-1:0]    nh_s1, nv_s1, nh_s2, nv_s2;
	logic signed [OVL_W-1:0]  ovl_s1, ovl_s2;
	logic signed [P_NV_W-1:0] pv_s1, ph_s1;
	logic signed [CLOSE_W-1:0] close_s2;

	logic signed [P_NC_W-1:0] phc_s3, pvc_s3;
	logic signed [P_OV_W-1:0] pch_s3, pcv_s3;
	logic signed [P_D_W-1:0]  pad_s3, pbd_s3;
	logic                     ov_s3, ov_s4, ov_s5;

	logic signed [CLOSE_W-1:0] hc_s4, tv_s4;
	logic signed [N_W-1:0]     ch_s4, cv_s4;
	logic signed [POS_W-1:0]   avv_sel_s4, bvv_sel_s4;
	logic signed [POS_W-1:0]   avv_sel, bvv_sel;

	logic signed [P_TH_W-1:0] pth_s5;
	logic signed [PP_W-1:0]   aph1_s5, apv1_s5, bph1_s5, bpv1_s5;
	logic signed [PP_W-1:0]   aph1_s6, apv1_s6, bph1_s6, bpv1_s6;
	logic signed [PP_W-1:0]   aph1_s7, apv1_s7, bph1_s7, bpv1_s7;
	logic signed [V1_W-1:0]   avv1_s5, bvv1_s5, avv1_s6, bvv1_s6, avv2_s7, bvv1_s7;

	logic signed [TH_W-1:0]   th;
	logic signed [H1_W-1:0]   avh1_s6, bvh1_s6, avh1_s7, bvh1_s7;
	logic signed [P_K_W-1:0]  pk_s6;
	logic                     keep_s6;
	logic signed [P_F_W-1:0]  pf_s7;
	logic                     gnd_s7;

	logic signed [H1_W-1:0]   avh2;
	logic signed [H1_W-1:0]   avh3, bvh3;
	out_t                     res_d;
	out_t                     res_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// vertical damping of the falling upper disc, before the exchange
	always_comb begin
		avv_sel = ctx_s3.orig.a_vel_v;
		bvv_sel = ctx_s3.orig.b_vel_v;
		if (ctx_s3.orig.a_pos_v < ctx_s3.orig.b_pos_v) begin
			if (ctx_s3.orig.b_vel_v < 0) begin
				bvv_sel = POS_W'(rnd_shr(WIDE_W'(pbd_s3), FRAC_BITS));
			end
		end else if (ctx_s3.orig.a_pos_v > ctx_s3.orig.b_pos_v) begin
			if (ctx_s3.orig.a_vel_v < 0) begin
				avv_sel = POS_W'(rnd_shr(WIDE_W'(pad_s3), FRAC_BITS));
			end
		end
	end

	always_comb begin
		th = TH_W'(rnd_shr(WIDE_W'(pth_s5), FRAC_BITS));
	end

	always_comb begin
		avh2 = gnd_s7 ? H1_W'(rnd_shr(WIDE_W'(pf_s7), FRAC_BITS)) : avh1_s7;
		avh3 = H1_W'(rnd_shr(WIDE_W'(avh2), 1));
		bvh3 = H1_W'(rnd_shr(WIDE_W'(bvh1_s7), 1));
		if (ctx_s7.touch) begin
			res_d.new_a_pos_h = sat32(WIDE_W'(aph1_s7));
			res_d.new_a_pos_v = sat32(WIDE_W'(apv1_s7));
			res_d.new_a_vel_h = sat32(WIDE_W'(avh3));
			res_d.new_a_vel_v = sat32(WIDE_W'(avv2_s7));
			res_d.new_b_pos_h = sat32(WIDE_W'(bph1_s7));
			res_d.new_b_pos_v = sat32(WIDE_W'(bpv1_s7));
			res_d.new_b_vel_h = sat32(WIDE_W'(bvh3));
			res_d.new_b_vel_v = sat32(WIDE_W'(bvv1_s7));
			res_d.touching    = 1'b1;
		end else begin
			res_d.new_a_pos_h = ctx_s7.orig.a_pos_h;
			res_d.new_a_pos_v = ctx_s7.orig.a_pos_v;
			res_d.new_a_vel_h = ctx_s7.orig.a_vel_h;
			res_d.new_a_vel_v = ctx_s7.orig.a_vel_v;
			res_d.new_b_pos_h = ctx_s7.orig.b_pos_h;
			res_d.new_b_pos_v = ctx_s7.orig.b_pos_v;
			res_d.new_b_vel_h = ctx_s7.orig.b_vel_h;
			res_d.new_b_vel_v = ctx_s7.orig.b_vel_v;
			res_d.touching    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		// closing speed products
		ctx_s1 <= in_ctx;
		nh_s1  <= nh;
		nv_s1  <= nv;
		ovl_s1 <= overlap;
		pv_s1  <= in_ctx.rvel_v * nv;
		ph_s1  <= in_ctx.rvel_h * nh;

		ctx_s2   <= ctx_s1;
		nh_s2    <= nh_s1;
		nv_s2    <= nv_s1;
		ovl_s2   <= ovl_s1;
		close_s2 <= CLOSE_W'(rnd_shr(WIDE_W'(pv_s1), FRAC_BITS))
			+ CLOSE_W'(rnd_shr(WIDE_W'(ph_s1), FRAC_BITS));

		ctx_s3 <= ctx_s2;
		ov_s3  <= ovl_s2 > 0;
		phc_s3 <= nh_s2 * close_s2;
		pvc_s3 <= nv_s2 * close_s2;
		pch_s3 <= nh_s2 * ovl_s2;
		pcv_s3 <= nv_s2 * ovl_s2;
		pad_s3 <= ctx_s2.orig.a_vel_v * K_DAMP;
		pbd_s3 <= ctx_s2.orig.b_vel_v * K_DAMP;

		ctx_s4     <= ctx_s3;
		ov_s4      <= ov_s3;
		hc_s4      <= CLOSE_W'(rnd_shr(WIDE_W'(phc_s3), FRAC_BITS));
		tv_s4      <= CLOSE_W'(rnd_shr(WIDE_W'(pvc_s3), FRAC_BITS));
		ch_s4      <= N_W'(rnd_shr(WIDE_W'(pch_s3), FRAC_BITS + 1));
		cv_s4      <= N_W'(rnd_shr(WIDE_W'(pcv_s3), FRAC_BITS + 1));
		avv_sel_s4 <= avv_sel;
		bvv_sel_s4 <= bvv_sel;

		// push apart and exchange normal speed
		ctx_s5 <= ctx_s4;
		ov_s5  <= ov_s4;
		pth_s5 <= hc_s4 * K_GAIN;
		if (ov_s4) begin
			aph1_s5 <= PP_W'(ctx_s4.orig.a_pos_h) - PP_W'(ch_s4);
			apv1_s5 <= PP_W'(ctx_s4.orig.a_pos_v) - PP_W'(cv_s4);
			bph1_s5 <= PP_W'(ctx_s4.orig.b_pos_h) + PP_W'(ch_s4);
			bpv1_s5 <= PP_W'(ctx_s4.orig.b_pos_v) + PP_W'(cv_s4);
			avv1_s5 <= V1_W'(avv_sel_s4) - V1_W'(tv_s4);
			bvv1_s5 <= V1_W'(bvv_sel_s4) + V1_W'(tv_s4);
		end else begin
			aph1_s5 <= PP_W'(ctx_s4.orig.a_pos_h);
			apv1_s5 <= PP_W'(ctx_s4.orig.a_pos_v);
			bph1_s5 <= PP_W'(ctx_s4.orig.b_pos_h);
			bpv1_s5 <= PP_W'(ctx_s4.orig.b_pos_v);
			avv1_s5 <= V1_W'(ctx_s4.orig.a_vel_v);
			bvv1_s5 <= V1_W'(ctx_s4.orig.b_vel_v);
		end

		ctx_s6  <= ctx_s5;
		aph1_s6 <= aph1_s5;
		apv1_s6 <= apv1_s5;
		bph1_s6 <= bph1_s5;
		bpv1_s6 <= bpv1_s5;
		avv1_s6 <= avv1_s5;
		bvv1_s6 <= bvv1_s5;
		pk_s6   <= avv1_s5 * K_KEEP;
		keep_s6 <= ov_s5 && (avv1_s5 < 0) && (bpv1_s5 < apv1_s5);
		if (ov_s5) begin
			avh1_s6 <= H1_W'(ctx_s5.orig.a_vel_h) - H1_W'(th);
			bvh1_s6 <= H1_W'(ctx_s5.orig.b_vel_h) + H1_W'(th);
		end else begin
			avh1_s6 <= H1_W'(ctx_s5.orig.a_vel_h);
			bvh1_s6 <= H1_W'(ctx_s5.orig.b_vel_h);
		end

		// upper disc damping and ground friction
		ctx_s7  <= ctx_s6;
		aph1_s7 <= aph1_s6;
		apv1_s7 <= apv1_s6;
		bph1_s7 <= bph1_s6;
		bpv1_s7 <= bpv1_s6;
		bvv1_s7 <= bvv1_s6;
		avh1_s7 <= avh1_s6;
		bvh1_s7 <= bvh1_s6;
		avv2_s7 <= keep_s6 ? V1_W'(rnd_shr(WIDE_W'(pk_s6), FRAC_BITS)) : avv1_s6;
		pf_s7   <= avh1_s6 * K_FRIC;
		gnd_s7  <= apv1_s6 <= ($signed(PP_W'(ctx_s6.orig.a_radius)) + PP_W'(K_GND));

		res_s8 <= res_d;
	end

	assign done   = v_s8;
	assign result = res_s8;

endmodule

[sv/ball_pair_collision_response.sv]
// ----------------------------------------------------------------------------
// ball_pair_collision_response
// Fixed-point collision response for one pair of discs per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A pair word is taken on req at a rising edge where start is high and busy
//   is low. busy is held low: the pipeline takes a new pair every cycle.
//   The result word shows on result for exactly one cycle, marked by done.
//   A pair passes through the front contact test (3 stages), the root
//   pipeline (one bit per stage, 25 stages), the normal dividers (one entry
//   stage plus one quotient bit per stage) and the 8-stage response path.
//   Throughput is one pair per clock; results leave in acceptance order.
//   The receiver cannot stall, so no result is ever held or dropped.
//   Reset clears all valid bits; words in flight are discarded and no
//   strobe appears until a new pair is accepted.
// ----------------------------------------------------------------------------
module ball_pair_collision_response (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  bpcr_pkg::in_t  req,
	output logic           done,
	output bpcr_pkg::out_t result
);
	import bpcr_pkg::*;

	logic                    v_s1, v_s2, v_s3;
	in_t                     req_s1;
	logic signed [POS_W:0]   dh_s1, dv_s1;
	logic [RSUM_W-1:0]       rsum_s1;
	logic                    near_s2;
	logic [SQ_W-1:0]         sqh_s2, sqv_s2, rsq_s2;
	ctx_t                    ctx_s2, ctx_s3;
	logic [SQ_W-1:0]         rad_s3;

	logic [POS_W:0]          mag_h, mag_v;
	logic signed [2*DIFF_W-1:0] sqh_full, sqv_full;
	logic [SQ_W:0]           d2;
	ctx_t                    ctx_d2;

	logic                    sq_v;
	logic [ROOT_W-1:0]       sq_root;
	ctx_t                    sq_ctx;
	logic                    dv_v;
	logic signed [N_W-1:0]   dv_nh, dv_nv;
	logic signed [OVL_W-1:0] dv_ovl;
	ctx_t                    dv_ctx;

	assign busy = 1'b0;

	always_comb begin
		mag_h    = dh_s1[POS_W] ? (POS_W + 1)'(-dh_s1) : (POS_W + 1)'(dh_s1);
		mag_v    = dv_s1[POS_W] ? (POS_W + 1)'(-dv_s1) : (POS_W + 1)'(dv_s1);
		sqh_full = $signed(dh_s1[DIFF_W-1:0]) * $signed(dh_s1[DIFF_W-1:0]);
		sqv_full = $signed(dv_s1[DIFF_W-1:0]) * $signed(dv_s1[DIFF_W-1:0]);
		d2       = {1'b0, sqh_s2} + {1'b0, sqv_s2};
		ctx_d2       = ctx_s2;
		ctx_d2.touch = near_s2 && (d2 <= {1'b0, rsq_s2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		req_s1  <= req;
		dh_s1   <= (POS_W + 1)'(req.b_pos_h) - (POS_W + 1)'(req.a_pos_h);
		dv_s1   <= (POS_W + 1)'(req.b_pos_v) - (POS_W + 1)'(req.a_pos_v);
		rsum_s1 <= RSUM_W'(req.a_radius) + RSUM_W'(req.b_radius);

		// squares are only meaningful once both offsets are within reach
		near_s2       <= (mag_h <= (POS_W + 1)'(rsum_s1)) && (mag_v <= (POS_W + 1)'(rsum_s1));
		sqh_s2        <= sqh_full[SQ_W-1:0];
		sqv_s2        <= sqv_full[SQ_W-1:0];
		rsq_s2        <= SQ_W'(rsum_s1) * SQ_W'(rsum_s1);
		ctx_s2.orig   <= req_s1;
		ctx_s2.touch  <= 1'b0;
		ctx_s2.dh     <= dh_s1[DIFF_W-1:0];
		ctx_s2.dv     <= dv_s1[DIFF_W-1:0];
		ctx_s2.rsum   <= rsum_s1;
		ctx_s2.rvel_h <= (POS_W + 1)'(req_s1.a_vel_h) - (POS_W + 1)'(req_s1.b_vel_h);
		ctx_s2.rvel_v <= (POS_W + 1)'(req_s1.a_vel_v) - (POS_W + 1)'(req_s1.b_vel_v);

		ctx_s3 <= ctx_d2;
		rad_s3 <= d2[SQ_W-1:0];
	end

	bpcr_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (v_s3),
		.rad     (rad_s3),
		.in_ctx  (ctx_s3),
		.out_v   (sq_v),
		.root    (sq_root),
		.out_ctx (sq_ctx)
	);

	bpcr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (sq_v),
		.span    (sq_root),
		.in_ctx  (sq_ctx),
		.out_v   (dv_v),
		.nh      (dv_nh),
		.nv      (dv_nv),
		.overlap (dv_ovl),
		.out_ctx (dv_ctx)
	);

	bpcr_resp u_resp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (dv_v),
		.nh      (dv_nh),
		.nv      (dv_nv),
		.overlap (dv_ovl),
		.in_ctx  (dv_ctx),
		.done    (done),
		.result  (result)
	);

endmodule
